// ----- rtl/mroe_pkg.sv -----
package mroe_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_READ       = 3'd1,
    OP_TRANSPOSE  = 3'd2,
    OP_SWAP_ROWS  = 3'd3,
    OP_SWAP_COLS  = 3'd4,
    OP_SCALE_ROW  = 3'd5,
    OP_ADD_ROWS   = 3'd6,
    OP_ADD_SCALED = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_CAPTURE,
    ST_MULTIPLY,
    ST_STORE_A,
    ST_STORE_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic        [IDX_W-1:0]   row_a;
    logic        [IDX_W-1:0]   row_b;
    logic        [IDX_W-1:0]   col_a;
    logic        [IDX_W-1:0]   col_b;
    logic signed [DATA_W-1:0]  element_value;
    logic signed [DATA_W-1:0]  scale_factor;
  } item_t;

  typedef struct packed {
    logic ready;
    logic take_item;
    logic clear_count;
    logic next_count;
    logic toggle_transpose;
    logic rd_p;
    logic rd_q;
    logic cap_a;
    logic cap_b;
    logic mul;
    logic wr_p;
    logic wr_q;
    logic load_read;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    bad_index;
    logic    last;
    logic    out_free;
  } ctrl_status_t;

endpackage

// ----- rtl/mroe_ram.sv -----
module mroe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/mroe_ctrl.sv -----
module mroe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  mroe_pkg::ctrl_status_t stat,
  output mroe_pkg::ctrl_cmd_t    cmd
);
  import mroe_pkg::*;

  state_t state;
  state_t state_next;

  logic is_swap;
  assign is_swap = (stat.op == OP_SWAP_ROWS) || (stat.op == OP_SWAP_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        // No item is taken while the block is held in reset.
        cmd.ready = !rst;
        if (in_valid && !rst) begin
          cmd.take_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clear_count = 1'b1;
        if (stat.bad_index) begin
          state_next = ST_DONE;
        end else begin
          case (stat.op)
            OP_WRITE:     state_next = ST_WRITE;
            OP_READ:      state_next = ST_READ_ADDR;
            OP_TRANSPOSE: begin
              cmd.toggle_transpose = 1'b1;
              state_next           = ST_DONE;
            end
            default:      state_next = ST_FETCH_A;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.wr_p   = 1'b1;
        state_next = ST_DONE;
      end
      ST_READ_ADDR: begin
        cmd.rd_p   = 1'b1;
        state_next = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        cmd.load_read = 1'b1;
        state_next    = ST_DONE;
      end
      ST_FETCH_A: begin
        cmd.rd_p   = 1'b1;
        state_next = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_q   = 1'b1;
        state_next = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd.cap_b  = 1'b1;
        state_next = is_swap ? ST_STORE_A : ST_MULTIPLY;
      end
      ST_MULTIPLY: begin
        cmd.mul    = 1'b1;
        state_next = ST_STORE_A;
      end
      ST_STORE_A: begin
        cmd.wr_p = 1'b1;
        if (is_swap) begin
          state_next = ST_STORE_B;
        end else begin
          cmd.next_count = 1'b1;
          state_next     = stat.last ? ST_DONE : ST_FETCH_A;
        end
      end
      ST_STORE_B: begin
        cmd.wr_q       = 1'b1;
        cmd.next_count = 1'b1;
        state_next     = stat.last ? ST_DONE : ST_FETCH_A;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_take_decodes: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> state == ST_DECODE)
    else $error("accepted item did not go to decode");

  a_toggle_op: assert property (@(posedge clk) disable iff (rst)
    cmd.toggle_transpose |-> stat.op == OP_TRANSPOSE && !stat.bad_index)
    else $error("orientation flipped by an operation other than transpose");

  a_second_store: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_q |-> $past(state) == ST_STORE_A && is_swap)
    else $error("second store outside a swap");

endmodule

// ----- rtl/mroe_datapath.sv -----
module mroe_datapath #(
  parameter int MAX_DIM       = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mroe_pkg::ctrl_cmd_t                  cmd,
  output mroe_pkg::ctrl_status_t               stat,
  input  mroe_pkg::item_t                      in_item,
  input  logic [mroe_pkg::DIM_W-1:0]           row_count,
  input  logic [mroe_pkg::DIM_W-1:0]           col_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_status,
  output logic signed [mroe_pkg::DATA_W-1:0]   out_read_value,
  output logic [mroe_pkg::DIM_W-1:0]           out_rows,
  output logic [mroe_pkg::DIM_W-1:0]           out_cols
);
  import mroe_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

  // Transpose is a fixed permutation of the square store, so it is kept as
  // a swap of the row and column roles in the address rather than a move.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c,
                                                  input logic             swap_rc);
    logic [ADDR_W-1:0] rr;
    logic [ADDR_W-1:0] cc;
    rr = swap_rc ? ADDR_W'(c) : ADDR_W'(r);
    cc = swap_rc ? ADDR_W'(r) : ADDR_W'(c);
    return rr * ADDR_W'(MAX_DIM) + cc;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] sum;
    logic signed [DATA_W-1:0] res;
    sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    res = sum[DATA_W-1:0];
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      res = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  item_t                     item_q;
  logic                      transposed;
  logic [DIM_W-1:0]          cnt;
  logic signed [DATA_W-1:0]  a_reg;
  logic signed [DATA_W-1:0]  b_reg;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [DATA_W-1:0]  read_result;

  logic [DIM_W-1:0]          rows_cur;
  logic [DIM_W-1:0]          cols_cur;
  logic [DIM_W-1:0]          loop_len;
  logic [DIM_W-1:0]          ra;
  logic [DIM_W-1:0]          rb;
  logic [DIM_W-1:0]          ca;
  logic [DIM_W-1:0]          cb;
  logic [DIM_W-1:0]          p_r;
  logic [DIM_W-1:0]          p_c;
  logic [DIM_W-1:0]          q_r;
  logic [DIM_W-1:0]          q_c;
  logic [ADDR_W-1:0]         p_addr;
  logic [ADDR_W-1:0]         q_addr;
  logic                      bad_index;
  logic signed [2*DATA_W-1:0] shifted;
  logic signed [DATA_W-1:0]  mul_sat;
  logic signed [DATA_W-1:0]  mul_operand;
  logic signed [DATA_W-1:0]  store_data;
  logic                      ram_wr_en;
  logic [ADDR_W-1:0]         ram_wr_addr;
  logic [DATA_W-1:0]         ram_wr_data;
  logic                      ram_rd_en;
  logic [ADDR_W-1:0]         ram_rd_addr;
  logic [DATA_W-1:0]         ram_rd_data;

  assign rows_cur = clamp_dim(transposed ? col_count : row_count);
  assign cols_cur = clamp_dim(transposed ? row_count : col_count);

  assign ra = DIM_W'(item_q.row_a);
  assign rb = DIM_W'(item_q.row_b);
  assign ca = DIM_W'(item_q.col_a);
  assign cb = DIM_W'(item_q.col_b);

  always_comb begin
    case (item_q.opcode)
      OP_WRITE, OP_READ:                     bad_index = (ra >= rows_cur) || (ca >= cols_cur);
      OP_TRANSPOSE:                          bad_index = 1'b0;
      OP_SWAP_COLS:                          bad_index = (ca >= cols_cur) || (cb >= cols_cur);
      OP_SCALE_ROW:                          bad_index = (ra >= rows_cur);
      OP_SWAP_ROWS, OP_ADD_ROWS, OP_ADD_SCALED: bad_index = (ra >= rows_cur) || (rb >= rows_cur);
      default:                               bad_index = 1'b1;
    endcase
  end

  // Column swap walks down the rows; every other loop walks along a row.
  assign loop_len = (item_q.opcode == OP_SWAP_COLS) ? rows_cur : cols_cur;

  always_comb begin
    case (item_q.opcode)
      OP_SWAP_COLS: begin
        p_r = cnt;
        p_c = ca;
        q_r = cnt;
        q_c = cb;
      end
      OP_WRITE, OP_READ: begin
        p_r = ra;
        p_c = ca;
        q_r = rb;
        q_c = cb;
      end
      default: begin
        p_r = ra;
        p_c = cnt;
        q_r = rb;
        q_c = cnt;
      end
    endcase
  end

  assign p_addr = phys_addr(p_r, p_c, transposed);
  assign q_addr = phys_addr(q_r, q_c, transposed);

  assign stat.op        = item_q.opcode;
  assign stat.bad_index = bad_index;
  assign stat.last      = (cnt == loop_len - DIM_W'(1));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      transposed <= 1'b0;
    end else if (cmd.toggle_transpose) begin
      transposed <= !transposed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_q <= in_item;
    end
    if (cmd.clear_count) begin
      cnt <= '0;
    end else if (cmd.next_count) begin
      cnt <= cnt + DIM_W'(1);
    end
    if (cmd.cap_a) begin
      a_reg <= ram_rd_data;
    end
    if (cmd.cap_b) begin
      b_reg <= ram_rd_data;
    end
    if (cmd.mul) begin
      prod <= item_q.scale_factor * mul_operand;
    end
    if (cmd.take_item) begin
      read_result <= '0;
    end else if (cmd.load_read) begin
      read_result <= ram_rd_data;
    end
  end

  assign mul_operand = (item_q.opcode == OP_SCALE_ROW) ? a_reg : b_reg;

  // An arithmetic shift of the full product rounds toward minus infinity.
  assign shifted = prod >>> FRACTION_BITS;

  always_comb begin
    mul_sat = shifted[DATA_W-1:0];
    if (!((&shifted[2*DATA_W-1:DATA_W-1]) || !(|shifted[2*DATA_W-1:DATA_W-1]))) begin
      mul_sat = shifted[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    case (item_q.opcode)
      OP_WRITE:      store_data = item_q.element_value;
      OP_SCALE_ROW:  store_data = mul_sat;
      OP_ADD_ROWS:   store_data = sat_add(a_reg, b_reg);
      OP_ADD_SCALED: store_data = sat_add(a_reg, mul_sat);
      default:       store_data = b_reg;
    endcase
  end

  assign ram_wr_en   = cmd.wr_p || cmd.wr_q;
  assign ram_wr_addr = cmd.wr_q ? q_addr : p_addr;
  assign ram_wr_data = cmd.wr_q ? a_reg : store_data;
  assign ram_rd_en   = cmd.rd_p || cmd.rd_q;
  assign ram_rd_addr = cmd.rd_q ? q_addr : p_addr;

  mroe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status     <= (item_q.opcode != OP_TRANSPOSE && bad_index) ? STATUS_BAD_INDEX
                                                                     : STATUS_OK;
      out_read_value <= read_result;
      out_rows       <= rows_cur;
      out_cols       <= cols_cur;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over one still waiting");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(ram_wr_en && ram_rd_en))
    else $error("store read and written in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.next_count |-> cnt < loop_len)
    else $error("element counter ran past the row or column");

endmodule

// ----- rtl/matrix_row_operation_engine.sv -----
// Matrix row-operation engine. It holds a matrix of signed Q16.16 elements of
// up to MAX_DIM by MAX_DIM and runs one operation per input item: write or
// read an element, transpose, swap rows, swap columns, scale a row, add a row
// to another, or add a scaled row. The input item carries the opcode in tuser
// and the indexes and operands in tdata; each item gives one result item with
// the status in tuser and the read value and current shape in tdata. The shape
// comes from the row_count and col_count registers. The user must write them
// only while idle; the block itself does not enforce this. An element write or
// read touches the store once, and transpose only flips the index mapping. Row
// and column operations walk the row or column one element at a time: each
// element takes two reads and a capture step through the element store, then,
// except for a swap, a multiply stage, and one write or, for a swap, two
// writes. A bad index goes from decode straight to done. A new item is taken
// only after the previous result has been loaded, and a finished item waits
// until the result before it has been taken by the receiver.
module matrix_row_operation_engine #(
  parameter int MAX_DIM       = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_a[2:0], row_b[5:3], col_a[8:6], col_b[11:9], element_value[43:12],
  // scale_factor[75:44], zero fill[79:76]
  input  logic [79:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value[31:0], rows_now[35:32], cols_now[39:36]
  output logic [39:0] m_axis_tdata,
  // status[0]
  output logic        m_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  import mroe_pkg::*;

  logic [DIM_W-1:0]         row_count;
  logic [DIM_W-1:0]         col_count;
  item_t                    in_item;
  ctrl_cmd_t                cmd;
  ctrl_status_t             stat;
  logic signed [DATA_W-1:0] out_read_value;
  logic [DIM_W-1:0]         out_rows;
  logic [DIM_W-1:0]         out_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.opcode        = opcode_t'(s_axis_tuser);
  assign in_item.row_a         = s_axis_tdata[2:0];
  assign in_item.row_b         = s_axis_tdata[5:3];
  assign in_item.col_a         = s_axis_tdata[8:6];
  assign in_item.col_b         = s_axis_tdata[11:9];
  assign in_item.element_value = s_axis_tdata[43:12];
  assign in_item.scale_factor  = s_axis_tdata[75:44];

  assign s_axis_tready = cmd.ready;

  mroe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .stat    (stat),
    .cmd     (cmd)
  );

  mroe_datapath #(
    .MAX_DIM      (MAX_DIM),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_item       (in_item),
    .row_count     (row_count),
    .col_count     (col_count),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_status    (m_axis_tuser),
    .out_read_value(out_read_value),
    .out_rows      (out_rows),
    .out_cols      (out_cols)
  );

  assign m_axis_tdata = {out_cols, out_rows, out_read_value};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mroe_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int FRACTION_BITS = 16;
  localparam logic signed [63:0] SAT_TOP    = 64'sd2147483647;
  localparam logic signed [63:0] SAT_BOTTOM = -64'sd2147483648;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic               status;
    logic signed [31:0] value;
    logic        [3:0]  rows;
    logic        [3:0]  cols;
  } outcome_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [3:0]  cfg_data = '0;

  matrix_row_operation_engine #(
    .MAX_DIM(MAX_DIM),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the matrix, its orientation and the shape registers.
  logic signed [31:0] cells [MAX_DIM*MAX_DIM];
  logic               flipped = 1'b0;
  logic [3:0]         cfg_rows = DIM_RESET;
  logic [3:0]         cfg_cols = DIM_RESET;

  item_t    op_backlog[$];
  outcome_t awaited_results[$];
  item_t    offered;

  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int errors = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  // Orientation the generator expects once every queued item has run.
  bit plan_flip = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [3:0] clamp_dim(logic [3:0] v);
    if (v == 0) return 4'd1;
    if (v > MAX_DIM) return 4'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [3:0] live_rows();
    return clamp_dim(flipped ? cfg_cols : cfg_rows);
  endfunction

  function automatic logic [3:0] live_cols();
    return clamp_dim(flipped ? cfg_rows : cfg_cols);
  endfunction

  function automatic int slot(logic [2:0] r, logic [2:0] c);
    return int'({r, c});
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > SAT_TOP) return SAT_TOP[31:0];
    if (v < SAT_BOTTOM) return SAT_BOTTOM[31:0];
    return v[31:0];
  endfunction

  // The arithmetic shift of the full product rounds toward minus infinity.
  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(p >>> FRACTION_BITS);
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] s;
    s = a + b;
    return sat32(s);
  endfunction

  function automatic outcome_t apply_row_op(item_t it);
    outcome_t           res;
    logic [3:0]         nr;
    logic [3:0]         nc;
    logic signed [31:0] t;
    logic signed [31:0] src;
    res = '0;
    res.status = STATUS_OK;
    nr = live_rows();
    nc = live_cols();
    case (it.opcode)
      OP_WRITE, OP_READ: begin
        if (it.row_a >= nr || it.col_a >= nc) begin
          res.status = STATUS_BAD_INDEX;
        end else if (it.opcode == OP_WRITE) begin
          cells[slot(it.row_a, it.col_a)] = it.element_value;
        end else begin
          res.value = cells[slot(it.row_a, it.col_a)];
        end
      end
      OP_TRANSPOSE: begin
        for (int i = 0; i < MAX_DIM; i++)
          for (int j = i + 1; j < MAX_DIM; j++) begin
            t = cells[slot(3'(i), 3'(j))];
            cells[slot(3'(i), 3'(j))] = cells[slot(3'(j), 3'(i))];
            cells[slot(3'(j), 3'(i))] = t;
          end
        flipped = ~flipped;
      end
      OP_SWAP_ROWS: begin
        if (it.row_a >= nr || it.row_b >= nr) begin
          res.status = STATUS_BAD_INDEX;
        end else begin
          for (int j = 0; j < nc; j++) begin
            t = cells[slot(it.row_a, 3'(j))];
            cells[slot(it.row_a, 3'(j))] = cells[slot(it.row_b, 3'(j))];
            cells[slot(it.row_b, 3'(j))] = t;
          end
        end
      end
      OP_SWAP_COLS: begin
        if (it.col_a >= nc || it.col_b >= nc) begin
          res.status = STATUS_BAD_INDEX;
        end else begin
          for (int i = 0; i < nr; i++) begin
            t = cells[slot(3'(i), it.col_a)];
            cells[slot(3'(i), it.col_a)] = cells[slot(3'(i), it.col_b)];
            cells[slot(3'(i), it.col_b)] = t;
          end
        end
      end
      OP_SCALE_ROW: begin
        if (it.row_a >= nr) begin
          res.status = STATUS_BAD_INDEX;
        end else begin
          for (int j = 0; j < nc; j++)
            cells[slot(it.row_a, 3'(j))] =
              qmul(cells[slot(it.row_a, 3'(j))], it.scale_factor);
        end
      end
      default: begin
        if (it.row_a >= nr || it.row_b >= nr) begin
          res.status = STATUS_BAD_INDEX;
        end else begin
          for (int j = 0; j < nc; j++) begin
            src = cells[slot(it.row_b, 3'(j))];
            if (it.opcode == OP_ADD_SCALED) src = qmul(it.scale_factor, src);
            cells[slot(it.row_a, 3'(j))] = qadd(cells[slot(it.row_a, 3'(j))], src);
          end
        end
      end
    endcase
    res.rows = live_rows();
    res.cols = live_cols();
    return res;
  endfunction

  function automatic int pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4, 5, 6: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t build_op(input opcode_t op, input logic [2:0] ra,
                                     input logic [2:0] rb, input logic [2:0] ca,
                                     input logic [2:0] cb, input logic [31:0] ev,
                                     input logic [31:0] sf);
    item_t it;
    it.opcode = op;
    it.row_a = ra;
    it.row_b = rb;
    it.col_a = ca;
    it.col_b = cb;
    it.element_value = ev;
    it.scale_factor = sf;
    if (op == OP_TRANSPOSE) plan_flip = ~plan_flip;
    return it;
  endfunction

  // Mostly in-shape indexes; a share of items carries arbitrary ones.
  function automatic item_t make_op(int broken_pct);
    logic [3:0]  nr;
    logic [3:0]  nc;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic [2:0]  ca;
    logic [2:0]  cb;
    opcode_t     op;
    int unsigned r;
    nr = clamp_dim(plan_flip ? cfg_cols : cfg_rows);
    nc = clamp_dim(plan_flip ? cfg_rows : cfg_cols);
    r = $urandom_range(0, 99);
    if (r < 22) op = OP_WRITE;
    else if (r < 40) op = OP_READ;
    else if (r < 45) op = OP_TRANSPOSE;
    else if (r < 55) op = OP_SWAP_ROWS;
    else if (r < 65) op = OP_SWAP_COLS;
    else if (r < 75) op = OP_SCALE_ROW;
    else if (r < 87) op = OP_ADD_ROWS;
    else op = OP_ADD_SCALED;
    ra = 3'($urandom);
    rb = 3'($urandom);
    ca = 3'($urandom);
    cb = 3'($urandom);
    if ($urandom_range(0, 99) >= broken_pct) begin
      ra = 3'($urandom_range(0, nr - 1));
      rb = 3'($urandom_range(0, nr - 1));
      ca = 3'($urandom_range(0, nc - 1));
      cb = 3'($urandom_range(0, nc - 1));
    end
    return build_op(op, ra, rb, ca, cb, pick_word(), pick_scale());
  endfunction

  task automatic write_reg(logic idx, logic [3:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_ROW_COUNT) cfg_rows = val;
    else cfg_cols = val;
  endtask

  task automatic set_shape(logic [3:0] r, logic [3:0] c);
    write_reg(REG_ROW_COUNT, r);
    write_reg(REG_COL_COUNT, c);
  endtask

  task automatic drain();
    while (op_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: offers queued items and records the expected outcome of each one taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(apply_row_op(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (op_backlog.size() != 0) begin
          offered = op_backlog.pop_front();
          s_axis_tdata <= {4'b0, offered.scale_factor, offered.element_value,
                           offered.col_b, offered.col_a, offered.row_b, offered.row_a};
          s_axis_tuser <= offered.opcode;
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_fault(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Monitor: checks each result item against the oldest expectation.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tdata[39:36]};
        if (awaited_results.size() == 0) begin
          flag_fault($sformatf("unexpected result item: status %0d value %h shape %0dx%0d",
                               got.status, got.value, got.rows, got.cols));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.rows !== want.rows || got.cols !== want.cols)
            flag_fault($sformatf(
              "mismatch: status %0d/%0d value %h/%h rows %0d/%0d cols %0d/%0d (exp/got)",
              want.status, got.status, want.value, got.value,
              want.rows, got.rows, want.cols, got.cols));
        end
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [3:0] nr;
    logic [3:0] nc;
    for (int i = 0; i < MAX_DIM * MAX_DIM; i++) cells[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every element is written once at full size, so no later operation
    // touches an element that was never written.
    set_shape(4'd8, 4'd8);
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < MAX_DIM; c++)
        op_backlog.push_back(build_op(OP_WRITE, 3'(r), 3'(0), 3'(c), 3'(0),
                                      pick_word(), 32'd0));
    drain();

    // Saturation at both ends, doubling a row onto itself, a swap of a row with
    // itself, swaps of two rows and of two columns, and reads through a transpose.
    op_backlog.push_back(build_op(OP_WRITE, 3'd7, 3'd0, 3'd7, 3'd0, 32'h7FFF_FFFF, 32'd0));
    op_backlog.push_back(build_op(OP_WRITE, 3'd0, 3'd7, 3'd0, 3'd7, 32'h8000_0000, 32'd0));
    op_backlog.push_back(build_op(OP_READ, 3'd7, 3'd0, 3'd7, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_ADD_ROWS, 3'd7, 3'd7, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_ADD_ROWS, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_READ, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_SCALE_ROW, 3'd7, 3'd0, 3'd0, 3'd0, 32'd0, 32'h7FFF_FFFF));
    op_backlog.push_back(build_op(OP_SCALE_ROW, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0, 32'h8000_0000));
    op_backlog.push_back(build_op(OP_SCALE_ROW, 3'd3, 3'd0, 3'd0, 3'd0, 32'd0, 32'h0001_0000));
    op_backlog.push_back(build_op(OP_ADD_SCALED, 3'd1, 3'd2, 3'd0, 3'd0, 32'd0, 32'hFFFF_0000));
    op_backlog.push_back(build_op(OP_SWAP_ROWS, 3'd2, 3'd2, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_SWAP_ROWS, 3'd0, 3'd7, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_SWAP_COLS, 3'd0, 3'd0, 3'd0, 3'd7, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_TRANSPOSE, 3'd5, 3'd6, 3'd1, 3'd2, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_READ, 3'd0, 3'd0, 3'd7, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_TRANSPOSE, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    drain();

    // Indexes just past the shape, in both orientations.
    set_shape(4'd3, 4'd5);
    op_backlog.push_back(build_op(OP_READ, 3'd3, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_WRITE, 3'd0, 3'd0, 3'd5, 3'd0, 32'h1234_5678, 32'd0));
    op_backlog.push_back(build_op(OP_SWAP_ROWS, 3'd0, 3'd3, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_SWAP_COLS, 3'd0, 3'd0, 3'd5, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_SCALE_ROW, 3'd4, 3'd0, 3'd0, 3'd0, 32'd0, 32'h0002_0000));
    op_backlog.push_back(build_op(OP_ADD_ROWS, 3'd0, 3'd7, 3'd0, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_TRANSPOSE, 3'd7, 3'd7, 3'd7, 3'd7, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_READ, 3'd4, 3'd0, 3'd2, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_READ, 3'd0, 3'd0, 3'd3, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_TRANSPOSE, 3'd0, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    drain();

    // Register values outside the legal range clamp to one and to the maximum.
    set_shape(4'd0, 4'd15);
    op_backlog.push_back(build_op(OP_READ, 3'd0, 3'd0, 3'd7, 3'd0, 32'd0, 32'd0));
    op_backlog.push_back(build_op(OP_READ, 3'd1, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin nr = 4'd8; nc = 4'd8; end
        1: begin nr = 4'd1; nc = 4'd1; end
        2: begin nr = 4'd2; nc = 4'd7; end
        3: begin nr = 4'd15; nc = 4'd0; end
        4: begin nr = 4'd5; nc = 4'd3; end
        7: begin nr = 4'd8; nc = 4'd8; end
        8: begin nr = 4'd3; nc = 4'd8; end
        default: begin nr = 4'($urandom); nc = 4'($urandom); end
      endcase
      set_shape(nr, nc);
      tx_calm = (ph == 3 || ph == 7);
      rx_calm = (ph == 3);
      // The receiver holds off while the sender keeps offering items.
      if (ph == 7) hold_ask++;
      repeat (136) op_backlog.push_back(make_op(15));
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- matrix_row_operation_engine.f -----
rtl/mroe_pkg.sv
rtl/mroe_ram.sv
rtl/mroe_ctrl.sv
rtl/mroe_datapath.sv
rtl/matrix_row_operation_engine.sv
bench/testbench.sv
